// File: rtl/cebg_pkg.sv
// Shared types, constants and helper functions for the category event budget gate.
// No dependencies; imported by every module of the block.
package cebg_pkg;

  localparam int NUM_CATEGORIES = 8;
  localparam int IDX_W          = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int NUM_SCAN       = (NUM_CATEGORIES < 8) ? NUM_CATEGORIES : 8;
  localparam int FALLBACK_IDX   = (NUM_CATEGORIES - 1 < 7) ? (NUM_CATEGORIES - 1) : 7;

  localparam int CNT_W      = 64;
  localparam int SKIP_W     = 32;
  localparam int BUDGET_W   = 31;
  localparam int CAT_W      = 8;
  localparam int CAT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(100000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_WINDOW  = 2'd0,
    REG_EVENT_BUDGET = 2'd1
  } cebg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_HELD = 2'd0,
    VERDICT_EMIT = 2'd1,
    VERDICT_SUPP = 2'd2
  } cebg_verdict_t;

  // Counter bank write request from the decision logic
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] emitted;
    logic [CNT_W-1:0] suppressed;
  } cebg_wr_t;

  // Lowest set bit of the scanned part of the mask; empty mask takes the fallback
  function automatic logic [IDX_W-1:0] pick_index(input logic [CAT_W-1:0] mask);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(FALLBACK_IDX);
    for (int i = NUM_SCAN - 1; i >= 0; i--) begin
      if (mask[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/cebg_cnt_bank.sv
// Per-category emitted and suppressed counter registers.
// Depends on cebg_pkg for widths and the write request struct.
module cebg_cnt_bank
  import cebg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [CNT_W-1:0] rd_emitted,
  output logic [CNT_W-1:0] rd_suppressed,
  input  cebg_wr_t         wr
);

  logic [CNT_W-1:0] emitted_r    [NUM_CATEGORIES];
  logic [CNT_W-1:0] suppressed_r [NUM_CATEGORIES];

  assign rd_emitted    = emitted_r[rd_idx];
  assign rd_suppressed = suppressed_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        emitted_r[i]    <= '0;
        suppressed_r[i] <= '0;
      end
    end else if (wr.we) begin
      emitted_r[wr.idx]    <= wr.emitted;
      suppressed_r[wr.idx] <= wr.suppressed;
    end
  end

endmodule

// File: rtl/cebg_decide.sv
// Window and budget decision for one item, producing the counter update.
// Depends on cebg_pkg for types, widths and sat_inc.
module cebg_decide
  import cebg_pkg::*;
(
  input  logic                go,
  input  logic [IDX_W-1:0]    idx,
  input  logic                mode,
  input  logic [CNT_W-1:0]    retired_count,
  input  logic [SKIP_W-1:0]   skip_window,
  input  logic [BUDGET_W-1:0] event_budget,
  input  logic [CNT_W-1:0]    emitted,
  input  logic [CNT_W-1:0]    suppressed,
  output cebg_verdict_t       verdict,
  output logic [CNT_W-1:0]    suppressed_total,
  output cebg_wr_t            wr
);

  logic [CNT_W-1:0] skip64;
  logic [CNT_W-1:0] e_lift;
  logic [CNT_W-1:0] e_used;
  logic             below_skip;
  logic             hold_evt;
  logic             hold_trc;
  logic             over;

  assign skip64     = {{(CNT_W-SKIP_W){1'b0}}, skip_window};
  assign below_skip = emitted < skip64;
  assign hold_evt   = !mode && below_skip;
  assign hold_trc   = mode && (retired_count < skip64);
  // lift the count to the window edge before the budget test
  assign e_lift     = below_skip ? skip64 : emitted;
  assign e_used     = e_lift - skip64;
  assign over       = e_used >= {{(CNT_W-BUDGET_W){1'b0}}, event_budget};

  always_comb begin
    wr.we         = go;
    wr.idx        = idx;
    wr.emitted    = emitted;
    wr.suppressed = suppressed;
    verdict       = VERDICT_HELD;
    if (hold_evt) begin
      wr.emitted = sat_inc(emitted);
    end else if (hold_trc) begin
      verdict = VERDICT_HELD;
    end else if (!over) begin
      verdict    = VERDICT_EMIT;
      wr.emitted = sat_inc(e_lift);
    end else begin
      verdict       = VERDICT_SUPP;
      wr.emitted    = e_lift;
      wr.suppressed = sat_inc(suppressed);
    end
    suppressed_total = wr.suppressed;
  end

endmodule

// File: rtl/category_event_budget_gate_core.sv
// Category event budget gate: one item in, one verdict out, accepted every cycle
// while the result channel is not stalled. Items pass an input register and a result
// register with the category counters updated between the two; the sustained rate is
// one item per clock while out_stall stays low. Each item's category mask is priority
// encoded (lowest set bit, or the last category when empty); the item is then held in
// the skip window, emitted within the category's budget, or counted as suppressed.
// Write skip_window and event_budget only while no item is in flight. Counters clear
// on reset and saturate at their maximum.
// Depends on cebg_pkg, cebg_cnt_bank and cebg_decide.
module category_event_budget_gate_core
  import cebg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CAT_W-1:0]      in_category,
  input  logic                  in_mode,
  input  logic [CNT_W-1:0]      in_retired_count,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_verdict,
  output logic [CAT_IDX_W-1:0]  out_category_index,
  output logic [CNT_W-1:0]      out_suppressed_total
);

  logic [SKIP_W-1:0]   skip_window_r;
  logic [BUDGET_W-1:0] event_budget_r;

  logic                a_valid_r;
  logic [IDX_W-1:0]    a_idx_r;
  logic                a_mode_r;
  logic [CNT_W-1:0]    a_retired_r;

  logic                out_valid_r;
  logic [1:0]          out_verdict_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [CNT_W-1:0]    out_supp_r;

  logic                out_adv;
  logic                a_move;
  logic                in_take;

  logic [CNT_W-1:0]    rd_emitted;
  logic [CNT_W-1:0]    rd_suppressed;
  cebg_verdict_t       verdict;
  logic [CNT_W-1:0]    supp_total;
  cebg_wr_t            wr;

  // Configuration registers: ignore writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_window_r  <= '0;
      event_budget_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SKIP_WINDOW:  skip_window_r  <= cfg_wdata[SKIP_W-1:0];
        REG_EVENT_BUDGET: event_budget_r <= cfg_wdata[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken this cycle;
  // the input register advances whenever the result register frees.
  assign out_adv  = !out_valid_r || !out_stall;
  assign a_move   = a_valid_r && out_adv;
  assign in_stall = a_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register: encode the category on entry to shorten the update path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_idx_r     <= pick_index(in_category);
      a_mode_r    <= in_mode;
      a_retired_r <= in_retired_count;
    end
  end

  cebg_cnt_bank u_cnt_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_idx        (a_idx_r),
    .rd_emitted    (rd_emitted),
    .rd_suppressed (rd_suppressed),
    .wr            (wr)
  );

  // Counters update exactly when the item moves into the result register
  cebg_decide u_decide (
    .go               (a_move),
    .idx              (a_idx_r),
    .mode             (a_mode_r),
    .retired_count    (a_retired_r),
    .skip_window      (skip_window_r),
    .event_budget     (event_budget_r),
    .emitted          (rd_emitted),
    .suppressed       (rd_suppressed),
    .verdict          (verdict),
    .suppressed_total (supp_total),
    .wr               (wr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_verdict_r <= verdict;
      out_idx_r     <= a_idx_r;
      out_supp_r    <= supp_total;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_verdict_r;
  assign out_category_index   = CAT_IDX_W'(out_idx_r);
  assign out_suppressed_total = out_supp_r;

  // A suppressed item always leaves a non-zero suppressed count behind
  a_supp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == VERDICT_SUPP) |-> out_supp_r != '0)
    else $error("suppressed verdict with zero suppressed total");

  // An item leaving the input register appears in the result register next cycle
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    a_move |=> out_valid_r)
    else $error("item lost between input and result register");

  // Counters are written only when an item moves on
  a_wr_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> (a_valid_r && out_adv))
    else $error("counter write without item transfer");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !a_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for category_event_budget_gate_core: a directed table, then
// random items under several window and budget settings, scored against hand-typed verdicts or a predictor.
// Depends on cebg_pkg and the gate RTL; needs no files or arguments.
module tb;
  import cebg_pkg::*;

  // Longest run of cycles with no handshake that a healthy block can show: the sender's longest
  // gap, the receiver's longest stall and the latency of the pipeline, with margin.
  localparam int QUIET_LIMIT       = 200;
  localparam int PIPE_DEPTH        = 2;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int NUM_SETTINGS      = 8;

  typedef struct packed {
    cebg_verdict_t          verdict;
    logic [CAT_IDX_W-1:0]   index;
    logic [CNT_W-1:0]       suppressed;
  } gate_result_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  // One line of the directed plan: either an item or a register write. Items with
  // typed set carry their verdict written out by hand; the rest go to the predictor.
  typedef struct packed {
    row_kind_t              kind;
    cebg_reg_t              target;
    logic [CFG_DATA_W-1:0]  value;
    logic [CAT_W-1:0]       category;
    logic                   mode;
    logic [CNT_W-1:0]       retired;
    logic                   typed;
    gate_result_t           want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [CAT_W-1:0]      in_category;
  logic                  in_mode;
  logic [CNT_W-1:0]      in_retired_count;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_verdict;
  logic [CAT_IDX_W-1:0]  out_category_index;
  logic [CNT_W-1:0]      out_suppressed_total;

  // Predictor state: our own copy of the registers and both counter banks
  logic [SKIP_W-1:0]     skip_cfg;
  logic [BUDGET_W-1:0]   budget_cfg;
  logic [CNT_W-1:0]      emit_count [NUM_CATEGORIES];
  logic [CNT_W-1:0]      supp_count [NUM_CATEGORIES];

  gate_result_t          pending_verdicts [$];
  plan_row_t             plan [$];

  // Hand-typed verdict for the item currently on the input channel, if any
  logic                  cur_typed;
  gate_result_t          cur_want;

  int                    fails;
  int                    quiet;
  int                    tx_max;
  int                    rx_max;
  int                    rx_wait;

  category_event_budget_gate_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_category          (in_category),
    .in_mode              (in_mode),
    .in_retired_count     (in_retired_count),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_category_index   (out_category_index),
    .out_suppressed_total (out_suppressed_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturating increment: hold the counter once it is all ones
  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  // Work out one item's verdict and advance the predictor's counters
  function automatic gate_result_t judge_event(input logic [CAT_W-1:0] cat, input logic m,
                                               input logic [CNT_W-1:0] rc);
    gate_result_t r;
    int           sel;
    bit           hit;
    logic [CNT_W-1:0] win;
    sel = FALLBACK_IDX;
    hit = 1'b0;
    // lowest set bit wins; bits beyond the counter bank are ignored
    for (int i = 0; i < NUM_SCAN; i++) begin
      if (!hit && cat[i]) begin
        sel = i;
        hit = 1'b1;
      end
    end
    win = CNT_W'(skip_cfg);
    if (!m && emit_count[sel] < win) begin
      // event-counted window: the held event still advances the category's count
      emit_count[sel] = count_up(emit_count[sel]);
      r.verdict = VERDICT_HELD;
    end else if (m && rc < win) begin
      // trace window: nothing moves until the instruction count reaches the window
      r.verdict = VERDICT_HELD;
    end else begin
      if (emit_count[sel] < win) emit_count[sel] = win;
      if (emit_count[sel] - win < CNT_W'(budget_cfg)) begin
        emit_count[sel] = count_up(emit_count[sel]);
        r.verdict = VERDICT_EMIT;
      end else begin
        supp_count[sel] = count_up(supp_count[sel]);
        r.verdict = VERDICT_SUPP;
      end
    end
    r.index      = CAT_IDX_W'(sel);
    r.suppressed = supp_count[sel];
    return r;
  endfunction

  function automatic plan_row_t event_row(input logic [CAT_W-1:0] cat, input logic m,
                                          input logic [CNT_W-1:0] rc);
    plan_row_t row;
    row          = '0;
    row.kind     = ROW_EVENT;
    row.category = cat;
    row.mode     = m;
    row.retired  = rc;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic [CAT_W-1:0] cat, input logic m,
                                          input logic [CNT_W-1:0] rc, input cebg_verdict_t v,
                                          input int idx, input logic [CNT_W-1:0] supp);
    plan_row_t row;
    row                 = event_row(cat, m, rc);
    row.typed           = 1'b1;
    row.want.verdict    = v;
    row.want.index      = CAT_IDX_W'(idx);
    row.want.suppressed = supp;
    return row;
  endfunction

  function automatic plan_row_t write_row(input cebg_reg_t target,
                                          input logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row        = '0;
    row.kind   = ROW_WRITE;
    row.target = target;
    row.value  = value;
    return row;
  endfunction

  // Half arbitrary masks, the rest single categories and the empty mask
  function automatic logic [CAT_W-1:0] rand_category();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick <= 4) return CAT_W'(1) << $urandom_range(0, CAT_W - 1);
    return CAT_W'($urandom);
  endfunction

  // Cluster instruction counts around the window edge so trace mode flips both ways
  function automatic logic [CNT_W-1:0] rand_retired();
    int unsigned pick;
    int unsigned off;
    pick = $urandom_range(0, 9);
    off  = $urandom_range(0, 6);
    if (pick <= 3) begin
      if ($urandom_range(0, 1)) return CNT_W'(skip_cfg) + CNT_W'(off);
      return (skip_cfg > off) ? CNT_W'(skip_cfg - off) : '0;
    end
    if (pick <= 6) return CNT_W'($urandom_range(0, 40));
    return {$urandom, $urandom};
  endfunction

  // Present one item after a random gap and hold it until the gate takes it.
  // Entered and left just after a rising edge.
  task automatic drive_item(input logic [CAT_W-1:0] cat, input logic m,
                            input logic [CNT_W-1:0] rc, input logic typed,
                            input gate_result_t want);
    int gap;
    gap = $urandom_range(0, tx_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_typed        = typed;
    cur_want         = want;
    in_category      = cat;
    in_mode          = m;
    in_retired_count = rc;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every outstanding item has produced its verdict
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // Write one register with the gate idle; mirror it into the predictor at the edge
  task automatic write_reg(input cebg_reg_t target, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    repeat (PIPE_DEPTH) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = target;
    cfg_wdata = value;
    @(posedge clk);
    if (target == REG_SKIP_WINDOW) skip_cfg = value;
    else budget_cfg = value[BUDGET_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: hold stall for the cycles drawn after each accepted result
  always @(negedge clk) begin
    out_stall = (rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  // Scoreboard and watchdog: predict on every accepted item, score every accepted result
  always @(posedge clk) begin : score
    gate_result_t model;
    gate_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        model = judge_event(in_category, in_mode, in_retired_count);
        pending_verdicts.push_back(cur_typed ? cur_want : model);
      end
      if (out_valid && !out_stall) begin
        rx_wait = $urandom_range(0, rx_max);
        if (pending_verdicts.size() == 0) begin
          $error("result with no item outstanding: verdict %0d, category_index %0d",
                 out_verdict, out_category_index);
          fails++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
            fails++;
          end
          if (out_category_index !== want.index) begin
            $error("category_index: expected %0d, got %0d", want.index, out_category_index);
            fails++;
          end
          if (out_suppressed_total !== want.suppressed) begin
            $error("suppressed_total: expected %0d, got %0d", want.suppressed,
                   out_suppressed_total);
            fails++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] skip_val;
    logic [CFG_DATA_W-1:0] budget_val;
    int                    pause_at;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_SKIP_WINDOW;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_category      = '0;
    in_mode          = 1'b0;
    in_retired_count = '0;
    out_stall        = 1'b0;
    cur_typed        = 1'b0;
    cur_want         = '0;
    fails            = 0;
    quiet            = 0;
    tx_max           = 6;
    rx_max           = 6;
    rx_wait          = 0;
    skip_cfg         = '0;
    budget_cfg       = BUDGET_RESET;
    for (int i = 0; i < NUM_CATEGORIES; i++) begin
      emit_count[i] = '0;
      supp_count[i] = '0;
    end

    // Directed plan. Out of reset: window 0, budget 100000, so everything emits.
    plan.push_back(typed_row(8'h00, 1'b0, '0, VERDICT_EMIT, 7, '0));   // empty mask
    plan.push_back(typed_row(8'h01, 1'b0, '0, VERDICT_EMIT, 0, '0));
    plan.push_back(typed_row(8'h80, 1'b1, '1, VERDICT_EMIT, 7, '0));
    plan.push_back(typed_row(8'hFF, 1'b0, '0, VERDICT_EMIT, 0, '0));   // full mask
    plan.push_back(typed_row(8'hF0, 1'b1, '0, VERDICT_EMIT, 4, '0));
    plan.push_back(event_row(8'h40, 1'b0, 64'h5A5A_0000_A5A5_FFFF));
    // small window and budget: hold three, emit two, then suppress
    plan.push_back(write_row(REG_SKIP_WINDOW, 32'd3));
    plan.push_back(write_row(REG_EVENT_BUDGET, 32'd2));
    plan.push_back(typed_row(8'h02, 1'b0, '0, VERDICT_HELD, 1, '0));
    for (int i = 0; i < 6; i++) plan.push_back(event_row(8'h02, 1'b0, '0));
    // trace mode: held below the window, then the counter is lifted to it
    plan.push_back(typed_row(8'h04, 1'b1, 64'd2, VERDICT_HELD, 2, '0));
    plan.push_back(event_row(8'h04, 1'b1, 64'd3));
    plan.push_back(event_row(8'h04, 1'b0, '0));
    plan.push_back(event_row(8'h04, 1'b0, '0));
    // widest window, zero budget
    plan.push_back(write_row(REG_SKIP_WINDOW, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_EVENT_BUDGET, 32'd0));
    plan.push_back(typed_row(8'h08, 1'b1, 64'hFFFF_FFFE, VERDICT_HELD, 3, '0));
    plan.push_back(typed_row(8'h08, 1'b1, 64'hFFFF_FFFF, VERDICT_SUPP, 3, 64'd1));
    plan.push_back(event_row(8'h08, 1'b0, '0));
    plan.push_back(event_row(8'h10, 1'b0, '0));
    // no window, largest budget: a lifted counter still lies past the budget
    plan.push_back(write_row(REG_SKIP_WINDOW, 32'd0));
    plan.push_back(write_row(REG_EVENT_BUDGET, 32'h7FFF_FFFF));
    plan.push_back(event_row(8'h08, 1'b0, '0));
    plan.push_back(event_row(8'h20, 1'b1, '0));
    plan.push_back(event_row(8'hA0, 1'b1, 64'h8000_0000_0000_0000));

    // Reset once, synchronously
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].target, plan[i].value);
      else drive_item(plan[i].category, plan[i].mode, plan[i].retired, plan[i].typed,
                      plan[i].want);
    end

    // Random part: one register setting per batch, extremes included
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin skip_val = 32'd0;             budget_val = 32'd100000;          end
        1: begin skip_val = 32'd4;             budget_val = 32'd3;               end
        2: begin skip_val = 32'd0;             budget_val = 32'd0;               end
        3: begin skip_val = 32'd1;             budget_val = 32'd1;               end
        4: begin skip_val = 32'd12;            budget_val = 32'd40;              end
        5: begin
          skip_val   = $urandom_range(0, 30);
          budget_val = $urandom_range(0, 20);
        end
        6: begin skip_val = 32'hFFFF_FFFF;     budget_val = 32'h7FFF_FFFF;       end
        default: begin skip_val = $urandom;    budget_val = $urandom >> 1;       end
      endcase
      write_reg(REG_SKIP_WINDOW, skip_val);
      write_reg(REG_EVENT_BUDGET, budget_val);
      pause_at = $urandom_range(20, ITEMS_PER_SETTING - 20);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        // redraw how hard each side idles; zero gives back-to-back stretches
        if (n % 50 == 0) begin
          tx_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
          rx_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
        end
        // hold the sender until the gate has fully emptied
        if (n == pause_at) drain_results();
        drive_item(rand_category(), 1'($urandom_range(0, 1)), rand_retired(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
